/* rtl/pfmu_pkg.sv */
// Package: shared item, control types and codes for the path fragment mate update block.
package pfmu_pkg;

    typedef enum logic
    {
        CMD_CLEAR = 1'b0,
        CMD_ADD   = 1'b1
    } cmd_t;

    localparam logic [1:0] FACTOR_REJECT = 2'd0;
    localparam logic [1:0] FACTOR_PATH   = 2'd1;
    localparam logic [1:0] FACTOR_CYCLE  = 2'd2;

    localparam logic [2:0] SIDE_COUNT_RESET = 3'd6;

    typedef struct packed
    {
        cmd_t       cmd;
        logic [2:0] band;
        logic [2:0] left_vertex;
        logic [2:0] right_vertex;
    } item_t;

    typedef struct packed
    {
        logic clear;
        logic write;
    } store_ctl_t;

endpackage

/* rtl/pfmu_band_store.sv */
// Band store: per-band row of endpoint degrees and mates, read and rewritten one row at a time, or all cleared.
module pfmu_band_store #(
    parameter int MAX_SIDE = 6
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [$clog2(MAX_SIDE)-1:0]                   band,
    input  pfmu_pkg::store_ctl_t                          ctl,
    input  logic [2*MAX_SIDE-1:0][1:0]                    wr_deg,
    input  logic [2*MAX_SIDE-1:0][$clog2(2*MAX_SIDE+1)-1:0] wr_mate,
    output logic [2*MAX_SIDE-1:0][1:0]                    rd_deg,
    output logic [2*MAX_SIDE-1:0][$clog2(2*MAX_SIDE+1)-1:0] rd_mate
);

    localparam int ENDS = 2 * MAX_SIDE;
    localparam int MW   = $clog2(ENDS + 1);

    logic [ENDS-1:0][1:0]    deg_reg  [MAX_SIDE];
    logic [ENDS-1:0][MW-1:0] mate_reg [MAX_SIDE];

    assign rd_deg  = deg_reg[band];
    assign rd_mate = mate_reg[band];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                deg_reg[i]  <= '0;
                mate_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < MAX_SIDE; i++)
            begin
                deg_reg[i]  <= '0;
                mate_reg[i] <= '0;
            end
        end
        else if (ctl.write)
        begin
            deg_reg[band]  <= wr_deg;
            mate_reg[band] <= wr_mate;
        end
    end

endmodule

/* rtl/pfmu_edge_update.sv */
// Edge update: range check, degree check and fragment grow/merge/close on one band row.
module pfmu_edge_update #(
    parameter int MAX_SIDE = 6
) (
    input  pfmu_pkg::item_t                                item,
    input  logic [2:0]                                     side_count,
    input  logic [2*MAX_SIDE-1:0][1:0]                     deg_i,
    input  logic [2*MAX_SIDE-1:0][$clog2(2*MAX_SIDE+1)-1:0] mate_i,
    output logic [2*MAX_SIDE-1:0][1:0]                     deg_o,
    output logic [2*MAX_SIDE-1:0][$clog2(2*MAX_SIDE+1)-1:0] mate_o,
    output logic                                           write,
    output logic [1:0]                                     factor
);

    localparam int ENDS = 2 * MAX_SIDE;
    localparam int EW   = $clog2(ENDS);
    localparam int MW   = $clog2(ENDS + 1);

    logic [3:0]    side_ext;
    logic [3:0]    limit;
    logic          in_range;
    logic [EW-1:0] iu;
    logic [EW-1:0] iv;
    logic [MW-1:0] code_u;
    logic [MW-1:0] code_v;
    logic [1:0]    du;
    logic [1:0]    dv;
    logic [MW-1:0] mu;
    logic [MW-1:0] mv;
    logic          mu_ok;
    logic          mv_ok;
    logic [EW-1:0] mu_idx;
    logic [EW-1:0] mv_idx;

    always_comb
    begin
        side_ext = {1'b0, side_count};
        limit    = (side_ext > 4'(MAX_SIDE)) ? 4'(MAX_SIDE) : side_ext;
        in_range = ({1'b0, item.band} < limit) && ({1'b0, item.left_vertex} < limit)
                   && ({1'b0, item.right_vertex} < limit);

        iu     = EW'(item.left_vertex);
        iv     = EW'(MAX_SIDE) + EW'(item.right_vertex);
        code_u = MW'(iu) + MW'(1);
        code_v = MW'(iv) + MW'(1);
        du     = deg_i[iu];
        dv     = deg_i[iv];
        mu     = mate_i[iu];
        mv     = mate_i[iv];
        mu_ok  = (mu != '0) && (mu <= MW'(ENDS));
        mv_ok  = (mv != '0) && (mv <= MW'(ENDS));
        mu_idx = EW'(mu - MW'(1));
        mv_idx = EW'(mv - MW'(1));

        deg_o  = deg_i;
        mate_o = mate_i;
        write  = 1'b0;
        factor = pfmu_pkg::FACTOR_REJECT;

        if (in_range && (du < 2'd2) && (dv < 2'd2))
        begin
            write  = 1'b1;
            factor = pfmu_pkg::FACTOR_PATH;
            if ((du == 2'd0) && (dv == 2'd0))
            begin
                deg_o[iu]  = 2'd1;
                deg_o[iv]  = 2'd1;
                mate_o[iu] = code_v;
                mate_o[iv] = code_u;
            end
            else if ((du == 2'd1) && (dv == 2'd0))
            begin
                deg_o[iu]  = 2'd2;
                mate_o[iu] = '0;
                deg_o[iv]  = 2'd1;
                mate_o[iv] = mu;
                if (mu_ok)
                begin
                    mate_o[mu_idx] = code_v;
                end
            end
            else if ((du == 2'd0) && (dv == 2'd1))
            begin
                deg_o[iv]  = 2'd2;
                mate_o[iv] = '0;
                deg_o[iu]  = 2'd1;
                mate_o[iu] = mv;
                if (mv_ok)
                begin
                    mate_o[mv_idx] = code_u;
                end
            end
            else
            begin
                deg_o[iu]  = 2'd2;
                deg_o[iv]  = 2'd2;
                mate_o[iu] = '0;
                mate_o[iv] = '0;
                if (mu == code_v)
                begin
                    factor = pfmu_pkg::FACTOR_CYCLE;
                end
                else if ((mu != '0) && (mv != '0))
                begin
                    if (mu_ok)
                    begin
                        mate_o[mu_idx] = mv;
                    end
                    if (mv_ok)
                    begin
                        mate_o[mv_idx] = mu;
                    end
                end
                else
                begin
                    if (mu_ok)
                    begin
                        mate_o[mu_idx] = '0;
                    end
                    if (mv_ok)
                    begin
                        mate_o[mv_idx] = '0;
                    end
                end
            end
        end
    end

endmodule

/* rtl/path_fragment_mate_update_core.sv */
// Top level: input register, band row update, result register and side count register.
// One word is accepted every cycle while the result side keeps up. An add-edge word is held
// in the input register, where its band row (all degrees and mates of that band, held in
// flip-flops) is read, updated and written back in the same cycle, and the factor then
// appears in the result register. A stalled result holds an add-edge word in the input
// register and stalls the input. A clear word empties every band when it leaves the input
// register and gives no result. Add-edge words with a band or vertex at or above side_count
// (capped at MAX_SIDE) give factor 0 and leave the store untouched. side_count is written
// through the cfg channel, which is always ready, and is registered before it is used.
module path_fragment_mate_update_core #(
    parameter int MAX_SIDE = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [2:0] band,
    input  logic [2:0] left_vertex,
    input  logic [2:0] right_vertex,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] factor
);

    localparam int ENDS = 2 * MAX_SIDE;
    localparam int MW   = $clog2(ENDS + 1);
    localparam int BW   = $clog2(MAX_SIDE);

    logic [2:0]             side_count_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    pfmu_pkg::item_t        s1_item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             factor_reg;
    logic                   accept;
    logic                   s1_go;
    logic                   s1_add;
    logic                   upd_write;
    logic [1:0]             upd_factor;
    pfmu_pkg::store_ctl_t   store_ctl;
    logic [ENDS-1:0][1:0]   rd_deg;
    logic [ENDS-1:0][MW-1:0] rd_mate;
    logic [ENDS-1:0][1:0]   wr_deg;
    logic [ENDS-1:0][MW-1:0] wr_mate;

    assign cfg_ready = 1'b1;
    assign s1_add    = (s1_item_reg.cmd == pfmu_pkg::CMD_ADD);
    assign s1_go     = s1_valid_reg && (!s1_add || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign accept    = in_valid && !in_stall;

    assign store_ctl.clear = s1_go && !s1_add;
    assign store_ctl.write = s1_go && s1_add && upd_write;

    assign out_valid = out_valid_reg;
    assign factor    = factor_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go && s1_add)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= pfmu_pkg::SIDE_COUNT_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                side_count_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.cmd          <= pfmu_pkg::cmd_t'(cmd);
            s1_item_reg.band         <= band;
            s1_item_reg.left_vertex  <= left_vertex;
            s1_item_reg.right_vertex <= right_vertex;
        end
        if (s1_go && s1_add)
        begin
            factor_reg <= upd_factor;
        end
    end

    pfmu_band_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .band    (s1_item_reg.band[BW-1:0]),
        .ctl     (store_ctl),
        .wr_deg  (wr_deg),
        .wr_mate (wr_mate),
        .rd_deg  (rd_deg),
        .rd_mate (rd_mate)
    );

    pfmu_edge_update #(
        .MAX_SIDE (MAX_SIDE)
    ) u_update (
        .item       (s1_item_reg),
        .side_count (side_count_reg),
        .deg_i      (rd_deg),
        .mate_i     (rd_mate),
        .deg_o      (wr_deg),
        .mate_o     (wr_mate),
        .write      (upd_write),
        .factor     (upd_factor)
    );

endmodule

/* tb/tb_path_fragment_mate_update_core.sv */
// Testbench: path fragment mate update core against a fragment/mate predictor that checks factors in order.
module tb_path_fragment_mate_update_core;

    localparam int SIDES = 6;
    localparam int ENDS  = 2 * SIDES;
    localparam int DEPTH = SIDES * ENDS;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    pfmu_pkg::item_t in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] factor;

    // predictor state
    logic [1:0] degree [DEPTH] = '{default: '0};
    logic [3:0] mate [DEPTH] = '{default: '0};
    logic [2:0] side_count = pfmu_pkg::SIDE_COUNT_RESET;

    pfmu_pkg::item_t word_queue [$];
    logic [1:0] factor_due [$];

    int send_idle_pct = 19;
    int recv_idle_pct = 55;
    int n_queued = 0;
    int n_accepted = 0;
    int n_clears = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_configs = 0;
    int n_factor [3] = '{0, 0, 0};

    path_fragment_mate_update_core #(
        .MAX_SIDE (SIDES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (in_word.cmd),
        .band         (in_word.band),
        .left_vertex  (in_word.left_vertex),
        .right_vertex (in_word.right_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .factor       (factor)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results still due", factor_due.size());
        $display("status: fail");
        $finish;
    end

    task automatic relink_end(input int r, input int code, input int e);
        if (code == 0 || code > ENDS)
            return;
        mate[r * ENDS + code - 1] = 4'(e + 1);
    endtask

    task automatic update_fragments(input pfmu_pkg::item_t w);
        int n, r, u, v, iu, iv, i, mu, mv;
        logic [1:0] du, dv, f;
        n = (side_count > SIDES) ? SIDES : int'(side_count);
        if (w.cmd == pfmu_pkg::CMD_CLEAR)
        begin
            for (i = 0; i < DEPTH; i++)
            begin
                degree[i] = '0;
                mate[i] = '0;
            end
            n_clears++;
            return;
        end
        r = w.band;
        if (r >= n || int'(w.left_vertex) >= n || int'(w.right_vertex) >= n)
            f = pfmu_pkg::FACTOR_REJECT;
        else
        begin
            u = w.left_vertex;
            v = SIDES + w.right_vertex;
            iu = r * ENDS + u;
            iv = r * ENDS + v;
            du = degree[iu];
            dv = degree[iv];
            mu = mate[iu];
            mv = mate[iv];
            if (du >= 2 || dv >= 2)
                f = pfmu_pkg::FACTOR_REJECT;
            else if (du == 0 && dv == 0)
            begin
                degree[iu] = 2'd1;
                degree[iv] = 2'd1;
                mate[iu] = 4'(v + 1);
                mate[iv] = 4'(u + 1);
                f = pfmu_pkg::FACTOR_PATH;
            end
            else if (du == 1 && dv == 0)
            begin
                degree[iu] = 2'd2;
                mate[iu] = '0;
                degree[iv] = 2'd1;
                mate[iv] = 4'(mu);
                relink_end(r, mu, v);
                f = pfmu_pkg::FACTOR_PATH;
            end
            else if (du == 0 && dv == 1)
            begin
                degree[iv] = 2'd2;
                mate[iv] = '0;
                degree[iu] = 2'd1;
                mate[iu] = 4'(mv);
                relink_end(r, mv, u);
                f = pfmu_pkg::FACTOR_PATH;
            end
            else
            begin
                degree[iu] = 2'd2;
                degree[iv] = 2'd2;
                mate[iu] = '0;
                mate[iv] = '0;
                if (mu == v + 1)
                    f = pfmu_pkg::FACTOR_CYCLE;
                else
                begin
                    f = pfmu_pkg::FACTOR_PATH;
                    if (mu != 0 && mv != 0)
                    begin
                        relink_end(r, mu, mv - 1);
                        relink_end(r, mv, mu - 1);
                    end
                    else
                    begin
                        // one far end missing: drop the mate of the other
                        if (mu != 0 && mu <= ENDS)
                            mate[r * ENDS + mu - 1] = '0;
                        if (mv != 0 && mv <= ENDS)
                            mate[r * ENDS + mv - 1] = '0;
                    end
                end
            end
        end
        factor_due.insert(factor_due.size(), f);
        n_factor[f]++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic fire;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            fire = in_valid && !in_stall;
            if (fire)
            begin
                update_fragments(in_word);
                n_accepted++;
            end
            if (!in_valid || fire)
            begin
                if (word_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    in_word <= word_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        logic [1:0] want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (factor_due.size() == 0)
                begin
                    if (n_errors < 10)
                        $display("unexpected word: factor %0d", factor);
                    n_errors++;
                end
                else
                begin
                    want = factor_due.pop_front();
                    n_checked++;
                    if (factor !== want)
                    begin
                        if (n_errors < 10)
                            $display("mismatch on result %0d: factor expected %0d got %0d",
                                     n_checked, want, factor);
                        n_errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    task automatic queue_word(input pfmu_pkg::cmd_t c, input int b, input int l, input int r);
        pfmu_pkg::item_t w;
        w.cmd = c;
        w.band = 3'(b);
        w.left_vertex = 3'(l);
        w.right_vertex = 3'(r);
        word_queue.insert(word_queue.size(), w);
        n_queued++;
    endtask

    // one closed cycle of 2k edges in one band, added in random order,
    // sometimes cut short so a path stays open
    task automatic queue_cycle(input int n);
        int k, b, i, j, m, t;
        int lv [SIDES];
        int rv [SIDES];
        int el [ENDS];
        int er [ENDS];
        k = $urandom_range(n, 1);
        b = $urandom_range(n - 1, 0);
        for (i = 0; i < n; i++)
        begin
            lv[i] = i;
            rv[i] = i;
        end
        for (i = 0; i < k; i++)
        begin
            j = $urandom_range(n - 1, i);
            t = lv[i]; lv[i] = lv[j]; lv[j] = t;
            j = $urandom_range(n - 1, i);
            t = rv[i]; rv[i] = rv[j]; rv[j] = t;
        end
        for (i = 0; i < k; i++)
        begin
            el[2 * i] = lv[i];
            er[2 * i] = rv[i];
            el[2 * i + 1] = lv[(i + 1) % k];
            er[2 * i + 1] = rv[i];
        end
        m = 2 * k;
        for (i = m - 1; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            t = el[i]; el[i] = el[j]; el[j] = t;
            t = er[i]; er[i] = er[j]; er[j] = t;
        end
        if ($urandom_range(99, 0) < 15)
            m--;
        if ($urandom_range(99, 0) < 20)
            queue_word(pfmu_pkg::CMD_CLEAR, $urandom_range(7, 0), $urandom_range(7, 0),
                       $urandom_range(7, 0));
        for (i = 0; i < m; i++)
            queue_word(pfmu_pkg::CMD_ADD, b, el[i], er[i]);
    endtask

    task automatic wait_drained();
        while (word_queue.size() != 0 || in_valid || factor_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_side_count(input logic [2:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        side_count = value;
        n_configs++;
    endtask

    initial
    begin
        logic [2:0] sweep [8];
        int s, n, start, target, guard;
        sweep = '{3'd2, 3'd7, 3'd3, 3'd0, 3'd1, 3'd4, 3'd5, 3'd6};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, rejects, extend on either side, merge, cycles, clear
        queue_word(pfmu_pkg::CMD_CLEAR, 7, 7, 7);
        queue_word(pfmu_pkg::CMD_ADD, 0, 0, 0);
        queue_word(pfmu_pkg::CMD_ADD, 0, 0, 0);
        queue_word(pfmu_pkg::CMD_ADD, 0, 0, 0);
        queue_word(pfmu_pkg::CMD_ADD, 5, 5, 5);
        queue_word(pfmu_pkg::CMD_ADD, 6, 0, 0);
        queue_word(pfmu_pkg::CMD_ADD, 7, 7, 7);
        queue_word(pfmu_pkg::CMD_ADD, 0, 6, 0);
        queue_word(pfmu_pkg::CMD_ADD, 0, 0, 7);
        queue_word(pfmu_pkg::CMD_ADD, 5, 0, 0);
        queue_word(pfmu_pkg::CMD_ADD, 5, 1, 1);
        queue_word(pfmu_pkg::CMD_ADD, 5, 1, 0);
        queue_word(pfmu_pkg::CMD_ADD, 5, 0, 1);
        queue_word(pfmu_pkg::CMD_ADD, 5, 2, 2);
        queue_word(pfmu_pkg::CMD_ADD, 5, 2, 3);
        queue_word(pfmu_pkg::CMD_ADD, 5, 3, 3);
        queue_word(pfmu_pkg::CMD_ADD, 5, 3, 2);
        queue_word(pfmu_pkg::CMD_CLEAR, 0, 0, 0);
        queue_word(pfmu_pkg::CMD_ADD, 0, 0, 0);
        wait_drained();

        for (s = 0; s < 8; s++)
        begin
            if (s == 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 19;
            end
            else if (s == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_side_count(sweep[s]);
            n = (sweep[s] > SIDES) ? SIDES : int'(sweep[s]);
            target = (n < 2) ? 40 : 250;
            start = n_queued;
            while (n_queued - start < target)
            begin
                if (n > 0 && $urandom_range(99, 0) < 75)
                    queue_cycle(n);
                else
                    queue_word(($urandom_range(15, 0) == 0) ? pfmu_pkg::CMD_CLEAR
                                                            : pfmu_pkg::CMD_ADD,
                               $urandom_range(7, 0), $urandom_range(7, 0),
                               $urandom_range(7, 0));
            end
            wait_drained();
        end

        guard = 0;
        while ((word_queue.size() != 0 || in_valid || factor_due.size() != 0) && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (factor_due.size() != 0)
        begin
            $display("%0d expected results never arrived", factor_due.size());
            n_errors += factor_due.size();
        end
        $display("run: %0d words in (%0d clears), %0d results checked, %0d side_count writes",
                 n_accepted, n_clears, n_checked, n_configs);
        $display("factors: %0d rejected, %0d path, %0d cycle; %0d mismatches",
                 n_factor[0], n_factor[1], n_factor[2], n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pfmu_pkg.sv
rtl/pfmu_band_store.sv
rtl/pfmu_edge_update.sv
rtl/path_fragment_mate_update_core.sv
tb/tb_path_fragment_mate_update_core.sv
